>>> rtl/rbs_pkg.sv
// Shared types and constants for the ray/box slab test pipeline.
// No dependencies; imported by every module of the block.
package rbs_pkg;

  // Divider: 32 quotient bits resolved over DivStages stages
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned DivStages     = 32 / StepsPerStage;
  // Registers from the input register to the divider output
  localparam int unsigned DivLatency    = DivStages + 2;
  // Select stages after the divider (last one is the output register)
  localparam int unsigned SelLatency    = 3;
  localparam int unsigned PipeDepth     = 1 + DivLatency + SelLatency;

  // Wide ray parameter: Q16.16 plus room for the unbounded marks
  localparam int unsigned TW = 35;
  localparam logic signed [TW-1:0] TInf   = 35'sh1_0000_0000;
  localparam logic signed [TW-1:0] TMiss  = -35'sd65536;
  localparam logic signed [TW-1:0] S32Max = 35'sh0_7FFF_FFFF;
  localparam logic signed [TW-1:0] S32Min = -35'sh0_8000_0000;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } rbs_req_t;

  typedef struct packed {
    logic signed [31:0] hit_distance;
    logic               hit_valid;
  } rbs_rsp_t;

  // Per-axis flags that ride alongside the dividers
  typedef struct packed {
    logic [2:0] dir_zero;
    logic [2:0] in_slab;
  } rbs_side_t;

endpackage

>>> rtl/ray_box_slab_test_core.sv
// Ray versus axis-aligned box slab test, signed Q16.16.
// Input request channel: in_valid_i / in_stall_o carrying rbs_req_t.
// Result channel: out_valid_o / out_stall_i carrying rbs_rsp_t, one result
// per request, in order. A transfer happens on a clock edge with valid high
// and stall low.
// Configuration: cfg_valid_i / cfg_ready_o writes tie_epsilon (ready is always
// high); write it only while no request is in flight. Reset value is 1.
// Throughput: one request per cycle while no result is held by out_stall_i.
// The pipeline has 14 register stages: the input register, the six
// parallel dividers (prep, 8 stages of 4 quotient bits, saturate) and three
// select stages; the last select stage is the output register.
// Reset (rst_ni low, asynchronous) clears all valid bits; tie_epsilon goes to 1.
// When out_stall_i is high with a result waiting, the whole pipeline holds
// and in_stall_o rises; nothing is dropped or repeated.
module ray_box_slab_test_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rbs_pkg::rbs_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rbs_pkg::rbs_rsp_t  out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);
  import rbs_pkg::*;

  logic [PipeDepth-1:0] valid_q;
  logic                 adv;
  logic [15:0]          eps_q;
  rbs_req_t             req_q;
  rbs_side_t            side_q [DivLatency];
  rbs_side_t            side_d;
  logic signed [31:0]   org [3], dir [3], bmin [3], bmax [3];
  logic signed [31:0]   qlo [3], qhi [3];

  assign adv         = !(valid_q[PipeDepth-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = valid_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      eps_q   <= 16'd1;
    end else begin
      if (adv) valid_q <= {valid_q[PipeDepth-2:0], in_valid_i};
      if (cfg_valid_i) eps_q <= cfg_data_i;
    end
  end

  assign org  = '{req_q.origin_x, req_q.origin_y, req_q.origin_z};
  assign dir  = '{req_q.dir_x, req_q.dir_y, req_q.dir_z};
  assign bmin = '{req_q.box_min_x, req_q.box_min_y, req_q.box_min_z};
  assign bmax = '{req_q.box_max_x, req_q.box_max_y, req_q.box_max_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_d.dir_zero[i] = dir[i] == '0;
      side_d.in_slab[i]  = (bmin[i] <= org[i]) && (org[i] <= bmax[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      req_q     <= in_req_i;
      side_q[0] <= side_d;
      for (int s = 1; s < DivLatency; s++) side_q[s] <= side_q[s-1];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_axis
    rbs_div_pipe u_div_lo (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (33'(bmin[i]) - 33'(org[i])),
      .den_i  (dir[i]),
      .quot_o (qlo[i])
    );
    rbs_div_pipe u_div_hi (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (33'(bmax[i]) - 33'(org[i])),
      .den_i  (dir[i]),
      .quot_o (qhi[i])
    );
  end

  rbs_select u_select (
    .clk_i  (clk_i),
    .en_i   (adv),
    .qlo_i  (qlo),
    .qhi_i  (qhi),
    .side_i (side_q[DivLatency-1]),
    .eps_i  (eps_q),
    .rsp_o  (out_rsp_o)
  );

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(valid_q))
    else $error("pipeline moved while result stalled");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted request not captured");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");
  a_hit_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.hit_valid == (out_rsp_o.hit_distance > 0)))
    else $error("hit flag disagrees with distance");

endmodule

>>> rtl/rbs_div_pipe.sv
// Pipelined signed Q16.16 divider: (num << 16) / den, truncated, saturated to 32 bits.
// Restoring division, StepsPerStage bits per stage. Depends on rbs_pkg.
module rbs_div_pipe (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [32:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] quot_o
);
  import rbs_pkg::*;

  logic [31:0] r_q  [DivStages+1];
  logic [31:0] nb_q [DivStages+1];
  logic [31:0] dv_q [DivStages+1];
  logic [31:0] q_q  [DivStages+1];
  logic        s_q  [DivStages+1];
  logic        ov_q [DivStages+1];
  logic [31:0] r_d  [DivStages];
  logic [31:0] nb_d [DivStages];
  logic [31:0] q_d  [DivStages];
  logic signed [31:0] quot_q, quot_d;

  logic [32:0] num_mag;
  logic [31:0] den_mag;

  always_comb begin
    num_mag = num_i[32] ? 33'(-num_i) : 33'(num_i);
    den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
  end

  // StepsPerStage compare/subtract steps per stage
  always_comb begin
    logic [32:0] t;
    logic [31:0] r, nb, q;
    for (int s = 0; s < DivStages; s++) begin
      r  = r_q[s];
      nb = nb_q[s];
      q  = q_q[s];
      for (int k = 0; k < StepsPerStage; k++) begin
        t = {r, nb[31]};
        if (t >= {1'b0, dv_q[s]}) begin
          r = 32'(t - {1'b0, dv_q[s]});
          q = {q[30:0], 1'b1};
        end else begin
          r = t[31:0];
          q = {q[30:0], 1'b0};
        end
        nb = {nb[30:0], 1'b0};
      end
      r_d[s]  = r;
      nb_d[s] = nb;
      q_d[s]  = q;
    end
  end

  always_comb begin
    logic [31:0] qm;
    qm = q_q[DivStages];
    if (!s_q[DivStages]) begin
      quot_d = (ov_q[DivStages] || qm[31]) ? 32'sh7FFF_FFFF : $signed(qm);
    end else begin
      quot_d = (ov_q[DivStages] || qm > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-qm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // high part of the scaled dividend is the starting remainder
      r_q[0]  <= {15'd0, num_mag[32:16]};
      nb_q[0] <= {num_mag[15:0], 16'd0};
      dv_q[0] <= den_mag;
      q_q[0]  <= '0;
      s_q[0]  <= num_i[32] ^ den_i[31];
      ov_q[0] <= {15'd0, num_mag[32:16]} >= den_mag;
      for (int s = 0; s < DivStages; s++) begin
        r_q[s+1]  <= r_d[s];
        nb_q[s+1] <= nb_d[s];
        dv_q[s+1] <= dv_q[s];
        q_q[s+1]  <= q_d[s];
        s_q[s+1]  <= s_q[s];
        ov_q[s+1] <= ov_q[s];
      end
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

>>> rtl/rbs_select.sv
// Slab combine: per-axis ordering, entry max / exit min, tie and miss selection.
// Three register stages, the last drives the result. Depends on rbs_pkg.
module rbs_select (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [31:0]  qlo_i [3],
  input  logic signed [31:0]  qhi_i [3],
  input  rbs_pkg::rbs_side_t  side_i,
  input  logic [15:0]         eps_i,
  output rbs_pkg::rbs_rsp_t   rsp_o
);
  import rbs_pkg::*;

  logic signed [TW-1:0] en_q [3], lv_q [3], en_d [3], lv_d [3];
  logic signed [TW-1:0] t0_q, t1_q, t0_d, t1_d;
  rbs_rsp_t rsp_q, rsp_d;

  always_comb begin
    logic signed [TW-1:0] a, b;
    for (int i = 0; i < 3; i++) begin
      a = TW'(qlo_i[i]);
      b = TW'(qhi_i[i]);
      if (side_i.dir_zero[i]) begin
        en_d[i] = side_i.in_slab[i] ? -TInf : TInf;
        lv_d[i] = side_i.in_slab[i] ? TInf : -TInf;
      end else begin
        en_d[i] = (a < b) ? a : b;
        lv_d[i] = (a < b) ? b : a;
      end
    end
  end

  always_comb begin
    t0_d = -TInf;
    t1_d = TInf;
    for (int i = 0; i < 3; i++) begin
      if (en_q[i] > t0_d) t0_d = en_q[i];
      if (lv_q[i] < t1_d) t1_d = lv_q[i];
    end
  end

  always_comb begin
    logic signed [TW-1:0] d, ad, res;
    d  = t1_q - t0_q;
    ad = d[TW-1] ? -d : d;
    priority if (ad < $signed({19'd0, eps_i})) begin
      res = t0_q;
    end else if (t1_q >= t0_q) begin
      res = (t0_q > 0) ? t0_q : t1_q;
    end else begin
      res = TMiss;
    end
    if (res > S32Max) res = S32Max;
    if (res < S32Min) res = S32Min;
    rsp_d.hit_distance = res[31:0];
    rsp_d.hit_valid    = res > 0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      en_q  <= en_d;
      lv_q  <= lv_d;
      t0_q  <= t0_d;
      t1_q  <= t1_d;
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

>>> dv/tb.sv
// Self-checking bench for ray_box_slab_test_core: random and directed ray/box
// requests, with a class-based predictor and in-order result check.
// Depends on rtl/rbs_pkg.sv and rtl/ray_box_slab_test_core.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbs_pkg::*;

  localparam longint SlabInf = longint'(1) << 40;
  localparam longint QOne    = 65536;
  localparam int     Drain   = 40;
  localparam int     Watchdog = 4000;

  class slab_scoreboard;
    rbs_rsp_t    pending[$];
    logic [15:0] eps = 16'd1;
    int          fails = 0;

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void slab(longint o, longint d, longint lo, longint hi,
                       output longint en, output longint lv);
      longint a, b;
      if (d == 0) begin
        if (lo <= o && o <= hi) begin
          en = -SlabInf; lv = SlabInf;
        end else begin
          en = SlabInf; lv = -SlabInf;
        end
      end else begin
        a = clamp32(((lo - o) * QOne) / d);
        b = clamp32(((hi - o) * QOne) / d);
        en = (a < b) ? a : b;
        lv = (a < b) ? b : a;
      end
    endfunction

    function void note_request(rbs_req_t r);
      longint t0, t1, en, lv, diff, hit;
      rbs_rsp_t e;
      t0 = -SlabInf;
      t1 = SlabInf;
      slab(r.origin_x, r.dir_x, r.box_min_x, r.box_max_x, en, lv);
      if (en > t0) t0 = en;
      if (lv < t1) t1 = lv;
      slab(r.origin_y, r.dir_y, r.box_min_y, r.box_max_y, en, lv);
      if (en > t0) t0 = en;
      if (lv < t1) t1 = lv;
      slab(r.origin_z, r.dir_z, r.box_min_z, r.box_max_z, en, lv);
      if (en > t0) t0 = en;
      if (lv < t1) t1 = lv;
      diff = t1 - t0;
      if (diff < 0) diff = -diff;
      if (diff < longint'(eps)) hit = t0;
      else if (t1 >= t0) hit = (t0 > 0) ? t0 : t1;
      else hit = -QOne;
      hit = clamp32(hit);
      e.hit_distance = hit[31:0];
      e.hit_valid    = hit > 0;
      pending = {pending, e};
    endfunction

    function void check_result(rbs_rsp_t got);
      rbs_rsp_t e;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.hit_distance !== e.hit_distance || got.hit_valid !== e.hit_valid) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: dist exp %h got %h, valid exp %b got %b",
                   e.hit_distance, got.hit_distance, e.hit_valid, got.hit_valid);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, cfg_valid_i, cfg_ready_o;
  rbs_req_t in_req_i;
  rbs_rsp_t out_rsp_o;
  logic [15:0] cfg_data_i;

  ray_box_slab_test_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  slab_scoreboard sb = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall chosen at the falling edge, result taken at the rising edge
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(out_rsp_o);
        quiet_cycles = 0;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      quiet_cycles++;
      if (quiet_cycles >= Watchdog) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(rbs_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    quiet_cycles = 0;
    @(negedge clk_i);
  endtask

  // Hold off until every result is back, then let the pipe go quiet
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_eps(logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.eps = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] any32();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic rbs_req_t noise_request();
    rbs_req_t r;
    r = {any32(), any32(), any32(), any32(), any32(), any32(),
         any32(), any32(), any32(), any32(), any32(), any32()};
    return r;
  endfunction

  // Sensible ray and box in a modest range; flat or zero direction now and then
  function automatic rbs_req_t box_request();
    logic [31:0] o[3], d[3], lo[3], hi[3];
    rbs_req_t r;
    for (int a = 0; a < 3; a++) begin
      o[a]  = $urandom_range(32'h0080_0000) - 32'h0040_0000;
      lo[a] = o[a] + $urandom_range(32'h0040_0000) - 32'h0020_0000;
      hi[a] = ($urandom_range(9) == 0) ? lo[a] : lo[a] + $urandom_range(32'h0020_0000);
      case ($urandom_range(9))
        0: d[a] = 32'd0;
        1: d[a] = $urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF;
        default: d[a] = $urandom_range(32'h0002_0000) - 32'h0001_0000;
      endcase
    end
    r = {o[0], o[1], o[2], d[0], d[1], d[2], lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    return r;
  endfunction

  function automatic rbs_req_t axis_request(logic [31:0] o, logic [31:0] d,
                                            logic [31:0] lo, logic [31:0] hi);
    rbs_req_t r;
    r = {o, o, o, d, d, d, lo, lo, lo, hi, hi, hi};
    return r;
  endfunction

  initial begin
    rbs_req_t r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: unbounded, misses, saturation, ties, inverted boxes
    send_request('0);
    send_request(axis_request(32'h0, 32'h0, 32'h1, 32'h2));
    send_request(axis_request(32'h8000_0000, 32'h1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_request(axis_request(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000));
    send_request(axis_request(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_request(axis_request(32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000));
    send_request(axis_request(32'h0, 32'h0001_0000, 32'hFFFE_0000, 32'hFFFE_0000));
    send_request(axis_request(32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000));
    send_request(axis_request(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0003_0000));
    send_request(axis_request(32'h0, 32'h0001_0000, 32'h0003_0000, 32'h0001_0000));
    send_request(axis_request(32'h0, 32'h0, 32'h0003_0000, 32'h0001_0000));
    send_request(axis_request(32'h0, 32'hFFFF_0000, 32'hFFFD_0000, 32'hFFFE_0000));
    send_request(axis_request(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    r = axis_request(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000);
    r.dir_y = '0;
    r.box_min_z = 32'h0005_0000;
    r.box_max_z = 32'h0006_0000;
    send_request(r);
    r.dir_z = '0;
    send_request(r);
    send_request({12{32'hFFFF_FFFF}});
    send_request({12{32'h8000_0000}});
    send_request({12{32'h7FFF_FFFF}});
    send_request({12{32'h5555_5555}});
    send_request({12{32'hAAAA_AAAA}});
    drain_pipe();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin write_eps(16'd0);    send_idle_pct = 24; recv_stall_pct = 75; end
        1: begin write_eps(16'hFFFF); send_idle_pct = 75; recv_stall_pct = 24; end
        default: begin
          write_eps(16'($urandom_range(16'hFFFF)));
          send_idle_pct = 0; recv_stall_pct = 0;
        end
      endcase
      for (int i = 0; i < 420; i++) begin
        if ($urandom_range(3) == 0) send_request(noise_request());
        else send_request(box_request());
        // an extra quiet spell mid-phase, with tie tolerance nudged
        if (p == 2 && i == 200) begin
          drain_pipe();
          write_eps(16'd1);
        end
      end
      drain_pipe();
    end

    if (sb.fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
